// File: sv/lfbs_pkg.sv
// Shared types and codes for the LED feedback blink sequencer.
// Depends on nothing; used by lfbs_engine and led_feedback_blink_sequencer.
package lfbs_pkg;

  // Request action codes. Codes above ActIdle behave as a tick.
  localparam logic [2:0] ActTick = 3'd0;
  localparam logic [2:0] ActRec  = 3'd1;
  localparam logic [2:0] ActWait = 3'd2;
  localparam logic [2:0] ActAck  = 3'd3;
  localparam logic [2:0] ActNack = 3'd4;
  localparam logic [2:0] ActIdle = 3'd5;

  // Sequencer mode codes, also reported on mode_now.
  localparam logic [2:0] ModeIdle = 3'd0;
  localparam logic [2:0] ModeRec  = 3'd1;
  localparam logic [2:0] ModeWait = 3'd2;
  localparam logic [2:0] ModeAck  = 3'd3;
  localparam logic [2:0] ModeNack = 3'd4;

  // Configuration register indexes.
  localparam logic [2:0] RegWaitPeriod = 3'd0;
  localparam logic [2:0] RegAckPeriod  = 3'd1;
  localparam logic [2:0] RegAckTotal   = 3'd2;
  localparam logic [2:0] RegNackPeriod = 3'd3;
  localparam logic [2:0] RegNackTotal  = 3'd4;

  localparam int unsigned CfgDataW = 16;

  // Configuration register file contents.
  typedef struct packed {
    logic [15:0] wait_period;
    logic [15:0] ack_period;
    logic [15:0] ack_total;
    logic [15:0] nack_period;
    logic [7:0]  nack_total;
  } cfg_t;

  // One result item.
  typedef struct packed {
    logic       green_on;
    logic       red_on;
    logic       finished;
    logic [2:0] mode_now;
  } result_t;

endpackage

// File: sv/lfbs_engine.sv
// Mode state machine and blink timing of the LED feedback blink sequencer.
// Depends on lfbs_pkg for codes, the configuration struct and the result struct.
module lfbs_engine #(
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   step_i,
  input  logic [2:0]             action_i,
  input  logic [TIME_BITS-1:0]   now_i,
  input  lfbs_pkg::cfg_t         cfg_i,
  output lfbs_pkg::result_t      res_o
);
  import lfbs_pkg::*;

  logic [2:0]           mode_q, mode_d;
  logic                 green_q, green_d;
  logic                 red_q, red_d;
  logic [TIME_BITS-1:0] last_q, last_d;
  logic [TIME_BITS-1:0] start_q, start_d;
  logic [8:0]           steps_q, steps_d;
  logic                 done;

  // Wrapping elapsed times and the threshold compares.
  logic [TIME_BITS-1:0] since_last;
  logic [TIME_BITS-1:0] since_start;
  logic                 wait_hit, ack_hit, ack_end, nack_hit, nack_end;
  logic [8:0]           steps_inc;

  assign since_last  = now_i - last_q;
  assign since_start = now_i - start_q;
  assign wait_hit    = since_last  >= TIME_BITS'(cfg_i.wait_period);
  assign ack_hit     = since_last  >= TIME_BITS'(cfg_i.ack_period);
  assign ack_end     = since_start >= TIME_BITS'(cfg_i.ack_total);
  assign nack_hit    = since_last  >= TIME_BITS'(cfg_i.nack_period);
  assign steps_inc   = steps_q + 9'd1;
  assign nack_end    = steps_inc >= {cfg_i.nack_total, 1'b0};

  // Next state for one request.
  always_comb begin
    mode_d  = mode_q;
    green_d = green_q;
    red_d   = red_q;
    last_d  = last_q;
    start_d = start_q;
    steps_d = steps_q;
    done    = 1'b0;
    unique case (action_i)
      ActRec: begin
        mode_d  = ModeRec;
        green_d = 1'b1;
        red_d   = 1'b0;
      end
      ActWait: begin
        mode_d  = ModeWait;
        green_d = 1'b0;
        red_d   = 1'b0;
        last_d  = now_i;
      end
      ActAck: begin
        mode_d  = ModeAck;
        green_d = 1'b0;
        red_d   = 1'b0;
        last_d  = now_i;
        start_d = now_i;
      end
      ActNack: begin
        mode_d  = ModeNack;
        green_d = 1'b0;
        red_d   = 1'b0;
        last_d  = now_i;
        steps_d = '0;
      end
      ActIdle: begin
        mode_d  = ModeIdle;
        green_d = 1'b0;
        red_d   = 1'b0;
      end
      default: begin
        // A tick, including the unused codes.
        if (mode_q == ModeWait) begin
          if (wait_hit) begin
            green_d = ~green_q;
            last_d  = now_i;
          end
        end else if (mode_q == ModeAck) begin
          if (ack_end) begin
            mode_d  = ModeIdle;
            green_d = 1'b0;
            red_d   = 1'b0;
            done    = 1'b1;
          end else if (ack_hit) begin
            green_d = ~green_q;
            last_d  = now_i;
          end
        end else if (mode_q == ModeNack) begin
          if (nack_hit) begin
            steps_d = steps_inc;
            red_d   = steps_inc[0];
            last_d  = now_i;
            if (nack_end) begin
              mode_d  = ModeIdle;
              green_d = 1'b0;
              red_d   = 1'b0;
              done    = 1'b1;
            end
          end
        end
      end
    endcase
  end

  // State registers advance once per processed request.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= ModeIdle;
      green_q <= 1'b0;
      red_q   <= 1'b0;
      last_q  <= '0;
      start_q <= '0;
      steps_q <= '0;
    end else if (step_i) begin
      mode_q  <= mode_d;
      green_q <= green_d;
      red_q   <= red_d;
      last_q  <= last_d;
      start_q <= start_d;
      steps_q <= steps_d;
    end
  end

  assign res_o.green_on = green_d;
  assign res_o.red_on   = red_d;
  assign res_o.finished = done;
  assign res_o.mode_now = mode_d;

endmodule

// File: sv/led_feedback_blink_sequencer.sv
// LED feedback blink sequencer: drives green and red status LEDs from mode requests and ticks.
// A request passes the input register and then the result register before its result is
// valid; throughput is one request per cycle while the result side does not stall, set by
// the state update in lfbs_engine. Reset clears mode to idle, both LEDs off, timestamps
// and the nack step count to zero, and loads the default configuration (500, 100, 1000,
// 150, 3). Depends on lfbs_pkg and lfbs_engine.
module led_feedback_blink_sequencer #(
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Configuration write port.
  input  logic                            cfg_we_i,
  input  logic [2:0]                      cfg_index_i,
  input  logic [lfbs_pkg::CfgDataW-1:0]   cfg_data_i,
  // Request channel.
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [2:0]                      action_i,
  input  logic [31:0]                     now_ms_i,
  // Result channel.
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            green_on_o,
  output logic                            red_on_o,
  output logic                            finished_o,
  output logic [2:0]                      mode_now_o
);
  import lfbs_pkg::*;

  cfg_t                 cfg_q;
  logic                 in_valid_q;
  logic [2:0]           action_q;
  logic [TIME_BITS-1:0] now_q;
  logic                 out_valid_q;
  result_t              res_q;
  result_t              res_d;
  logic                 advance;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.wait_period <= 16'd500;
      cfg_q.ack_period  <= 16'd100;
      cfg_q.ack_total   <= 16'd1000;
      cfg_q.nack_period <= 16'd150;
      cfg_q.nack_total  <= 8'd3;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegWaitPeriod: cfg_q.wait_period <= cfg_data_i;
        RegAckPeriod:  cfg_q.ack_period  <= cfg_data_i;
        RegAckTotal:   cfg_q.ack_total   <= cfg_data_i;
        RegNackPeriod: cfg_q.nack_period <= cfg_data_i;
        RegNackTotal:  cfg_q.nack_total  <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // The held request moves on when the result register is free or being drained.
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      action_q <= action_i;
      now_q    <= TIME_BITS'(now_ms_i);
    end
  end

  lfbs_engine #(
    .TIME_BITS(TIME_BITS)
  ) u_engine (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .action_i (action_q),
    .now_i    (now_q),
    .cfg_i    (cfg_q),
    .res_o    (res_d)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign green_on_o  = res_q.green_on;
  assign red_on_o    = res_q.red_on;
  assign finished_o  = res_q.finished;
  assign mode_now_o  = res_q.mode_now;

endmodule

// File: sim/lfbs_led_checker.sv
// Result checker for led_feedback_blink_sequencer: tracks the LED sequencer state per request.
// Watches the configuration port and both channels; depends on lfbs_pkg for codes and types.
module lfbs_led_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_stall_o,
  input  logic [2:0]  action_i,
  input  logic [31:0] now_ms_i,
  input  logic        out_valid_o,
  input  logic        out_stall_i,
  input  logic        green_on_o,
  input  logic        red_on_o,
  input  logic        finished_o,
  input  logic [2:0]  mode_now_o,
  output int          fail_count_o,
  output int          pending_o
);
  import lfbs_pkg::*;

  // Shadow configuration.
  logic [15:0] wait_period;
  logic [15:0] ack_period;
  logic [15:0] ack_total;
  logic [15:0] nack_period;
  logic [7:0]  nack_total;

  // Shadow sequencer state.
  logic [2:0]  mode;
  logic        green_lvl;
  logic        red_lvl;
  logic [31:0] last_toggle_ms;
  logic [31:0] flash_start_ms;
  logic [8:0]  half_periods;

  // LED levels expected for accepted requests, oldest first.
  result_t expected_leds[$];

  // Every command first turns both LEDs off.
  function automatic void enter_mode(input logic [2:0] m);
    green_lvl = 1'b0;
    red_lvl   = 1'b0;
    mode      = m;
  endfunction

  // Advance the shadow state by one request and return the LED levels it leaves.
  function automatic result_t step_leds(input logic [2:0] act, input logic [31:0] now);
    result_t     r;
    logic        done;
    logic [31:0] since_toggle;
    logic [31:0] since_start;
    done         = 1'b0;
    since_toggle = now - last_toggle_ms;
    since_start  = now - flash_start_ms;
    case (act)
      ActRec: begin
        enter_mode(ModeRec);
        green_lvl = 1'b1;
      end
      ActWait: begin
        enter_mode(ModeWait);
        last_toggle_ms = now;
      end
      ActAck: begin
        enter_mode(ModeAck);
        flash_start_ms = now;
        last_toggle_ms = now;
      end
      ActNack: begin
        enter_mode(ModeNack);
        half_periods   = '0;
        last_toggle_ms = now;
      end
      ActIdle: begin
        enter_mode(ModeIdle);
      end
      default: begin
        // Ticks, including the unused codes; idle and recording ignore them.
        if (mode == ModeWait) begin
          if (since_toggle >= {16'd0, wait_period}) begin
            green_lvl      = !green_lvl;
            last_toggle_ms = now;
          end
        end else if (mode == ModeAck) begin
          if (since_start >= {16'd0, ack_total}) begin
            enter_mode(ModeIdle);
            done = 1'b1;
          end else if (since_toggle >= {16'd0, ack_period}) begin
            green_lvl      = !green_lvl;
            last_toggle_ms = now;
          end
        end else if (mode == ModeNack) begin
          if (since_toggle >= {16'd0, nack_period}) begin
            half_periods   = half_periods + 9'd1;
            red_lvl        = half_periods[0];
            last_toggle_ms = now;
            if (half_periods >= {nack_total, 1'b0}) begin
              enter_mode(ModeIdle);
              done = 1'b1;
            end
          end
        end
      end
    endcase
    r.green_on = green_lvl;
    r.red_on   = red_lvl;
    r.finished = done;
    r.mode_now = mode;
    return r;
  endfunction

  // Sample both channels at the clock edge; results are retired before new requests.
  always @(posedge clk_i or negedge rst_ni) begin : watch
    result_t want;
    if (!rst_ni) begin
      wait_period    = 16'd500;
      ack_period     = 16'd100;
      ack_total      = 16'd1000;
      nack_period    = 16'd150;
      nack_total     = 8'd3;
      mode           = ModeIdle;
      green_lvl      = 1'b0;
      red_lvl        = 1'b0;
      last_toggle_ms = '0;
      flash_start_ms = '0;
      half_periods   = '0;
      expected_leds.delete();
      fail_count_o   = 0;
      pending_o      = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          RegWaitPeriod: wait_period = cfg_data_i;
          RegAckPeriod:  ack_period  = cfg_data_i;
          RegAckTotal:   ack_total   = cfg_data_i;
          RegNackPeriod: nack_period = cfg_data_i;
          RegNackTotal:  nack_total  = cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (out_valid_o && !out_stall_i) begin
        if (expected_leds.size() == 0) begin
          $display("%0t: result with nothing expected: green %0b red %0b finished %0b mode %0d",
                   $time, green_on_o, red_on_o, finished_o, mode_now_o);
          fail_count_o++;
        end else begin
          want = expected_leds.pop_front();
          if (green_on_o !== want.green_on) begin
            $display("%0t: green_on expected %0b, got %0b", $time, want.green_on, green_on_o);
            fail_count_o++;
          end
          if (red_on_o !== want.red_on) begin
            $display("%0t: red_on expected %0b, got %0b", $time, want.red_on, red_on_o);
            fail_count_o++;
          end
          if (finished_o !== want.finished) begin
            $display("%0t: finished expected %0b, got %0b", $time, want.finished, finished_o);
            fail_count_o++;
          end
          if (mode_now_o !== want.mode_now) begin
            $display("%0t: mode_now expected %0d, got %0d", $time, want.mode_now, mode_now_o);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        expected_leds.push_back(step_leds(action_i, now_ms_i));
      end
      pending_o = expected_leds.size();
    end
  end

endmodule

// File: sim/tb_led_feedback_blink_sequencer.sv
// Testbench top for led_feedback_blink_sequencer: directed and random mode requests and ticks.
// Depends on lfbs_pkg, the sequencer RTL and lfbs_led_checker, which does the comparison.
module tb_led_feedback_blink_sequencer;
  import lfbs_pkg::*;

  localparam int          ItemsPerPhase = 175;
  localparam int          NumPhases     = 7;
  localparam int          CycleLimit    = 200000;
  // Action codes the sequencer treats as a tick.
  localparam logic [2:0]  ActSpareLo    = 3'd6;
  localparam logic [2:0]  ActSpareHi    = 3'd7;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_index_i;
  logic [15:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [2:0]  action_i;
  logic [31:0] now_ms_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic        green_on_o;
  logic        red_on_o;
  logic        finished_o;
  logic [2:0]  mode_now_o;

  int          fail_count;
  int          pending;
  int          cycle_count;
  int          send_calm;
  int          recv_calm;
  logic [15:0] cfg_val [5];
  logic [31:0] cursor_ms;

  led_feedback_blink_sequencer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .action_i    (action_i),
    .now_ms_i    (now_ms_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .green_on_o  (green_on_o),
    .red_on_o    (red_on_o),
    .finished_o  (finished_o),
    .mode_now_o  (mode_now_o)
  );

  lfbs_led_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .action_i     (action_i),
    .now_ms_i     (now_ms_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .green_on_o   (green_on_o),
    .red_on_o     (red_on_o),
    .finished_o   (finished_o),
    .mode_now_o   (mode_now_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Result side stalls at random, with occasional long stretches without stalls.
  initial begin
    out_stall_i = 1'b0;
    recv_calm   = 0;
    forever begin
      @(negedge clk_i);
      if (recv_calm > 0) begin
        recv_calm--;
        out_stall_i <= 1'b0;
      end else if ($urandom_range(0, 399) == 0) begin
        recv_calm = 300;
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < 9);
      end
    end
  end

  // Guard against a hang; the counter starts from the default value of an int.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Offer one request, at random after a pause with valid low, and hold it until accepted.
  task automatic send_request(input logic [2:0] act, input logic [31:0] stamp);
    if (send_calm > 0) begin
      send_calm--;
    end else if ($urandom_range(0, 399) == 0) begin
      send_calm = 300;
    end else if ($urandom_range(0, 99) < 9) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i   <= act;
    now_ms_i   <= stamp;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  // Stop offering requests and wait until every expected result has come back.
  task automatic drain;
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    cfg_val[idx] = val;
    @(negedge clk_i);
  endtask

  // Load all five registers while the block is idle.
  task automatic program_regs(input logic [15:0] wp, input logic [15:0] ap,
                              input logic [15:0] at, input logic [15:0] np,
                              input logic [15:0] nt);
    write_reg(RegWaitPeriod, wp);
    write_reg(RegAckPeriod, ap);
    write_reg(RegAckTotal, at);
    write_reg(RegNackPeriod, np);
    write_reg(RegNackTotal, nt);
    cfg_we_i <= 1'b0;
  endtask

  // Next timestamp: mostly forward by up to two periods, sometimes backward or anywhere.
  function automatic logic [31:0] next_stamp(input int span);
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 5) begin
      cursor_ms = $urandom;
    end else if (pick < 9) begin
      cursor_ms = cursor_ms - $urandom_range(0, span);
    end else begin
      cursor_ms = cursor_ms + $urandom_range(0, 2 * span);
    end
    return cursor_ms;
  endfunction

  // Random phase: mostly a command followed by a run of ticks, plus some noise.
  task automatic run_phase(input int count);
    int          sent;
    int          pick;
    int          ticks;
    int          span;
    logic [2:0]  cmd;
    logic [2:0]  act;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        send_request(3'($urandom_range(0, 7)), $urandom);
        sent++;
      end else begin
        if (pick < 25) begin
          cmd = $urandom_range(0, 1) ? ActRec : ActIdle;
        end else begin
          case ($urandom_range(0, 2))
            0:       cmd = ActWait;
            1:       cmd = ActAck;
            default: cmd = ActNack;
          endcase
        end
        case (cmd)
          ActWait: span = cfg_val[RegWaitPeriod];
          ActAck:  span = cfg_val[RegAckPeriod];
          ActNack: span = cfg_val[RegNackPeriod];
          default: span = 100;
        endcase
        send_request(cmd, next_stamp(span));
        sent++;
        ticks = $urandom_range(1, 40);
        for (int k = 0; k < ticks && sent < count; k++) begin
          if ($urandom_range(0, 19) == 0) begin
            act = $urandom_range(0, 1) ? ActSpareLo : ActSpareHi;
          end else begin
            act = ActTick;
          end
          send_request(act, next_stamp(span));
          sent++;
        end
      end
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_index_i = RegWaitPeriod;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    action_i    = ActTick;
    now_ms_i    = '0;
    send_calm   = 0;
    cursor_ms   = '0;
    cfg_val[RegWaitPeriod] = 16'd500;
    cfg_val[RegAckPeriod]  = 16'd100;
    cfg_val[RegAckTotal]   = 16'd1000;
    cfg_val[RegNackPeriod] = 16'd150;
    cfg_val[RegNackTotal]  = 16'd3;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part under the reset configuration.
    send_request(ActTick, 32'h0000_0000);
    send_request(ActSpareHi, 32'hFFFF_FFFF);
    send_request(ActRec, 32'd5);
    send_request(ActTick, 32'd900);
    send_request(ActSpareLo, 32'd2000);
    // Waiting toggles across the timestamp wrap.
    send_request(ActWait, 32'hFFFF_FF00);
    send_request(ActTick, 32'hFFFF_FF00 + 32'd499);
    send_request(ActTick, 32'hFFFF_FF00 + 32'd500);
    // Ack flash toggles twice and then ends on the total duration.
    send_request(ActAck, 32'd1000);
    send_request(ActTick, 32'd1100);
    send_request(ActTick, 32'd1999);
    send_request(ActTick, 32'd2000);
    // Nack flash runs three red blinks, six half-periods.
    send_request(ActNack, 32'd0);
    for (int k = 1; k <= 6; k++) begin
      send_request(ActTick, 32'(150 * k));
    end
    send_request(ActIdle, 32'hFFFF_FFFF);
    drain();

    // Random phases across several register settings, the extremes included.
    for (int ph = 0; ph < NumPhases; ph++) begin
      cursor_ms = $urandom;
      case (ph)
        0: ;
        1: program_regs(16'd1, 16'd1, 16'd1, 16'd1, 16'd1);
        2: begin
          program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd255);
          cursor_ms = 32'hFFFF_0000;
        end
        6: program_regs(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)),
                        16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)),
                        16'($urandom_range(1, 255)));
        default: program_regs(16'($urandom_range(1, 50)), 16'($urandom_range(1, 50)),
                              16'($urandom_range(1, 400)), 16'($urandom_range(1, 50)),
                              16'($urandom_range(1, 8)));
      endcase
      run_phase(ItemsPerPhase);
      drain();
    end

    repeat (10) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
